// File: hdl/depth_grid_triangle_strip_builder_assert.svh
// Assertion macros used by the checker of this block.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef DEPTH_GRID_TRIANGLE_STRIP_BUILDER_ASSERT_SVH
`define DEPTH_GRID_TRIANGLE_STRIP_BUILDER_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define DGTSB_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// When the trigger holds, the consequence holds at the next clock edge.
`define DGTSB_ASSERT_NEXT(lbl, trig, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/dgtsb_pkg.sv
`timescale 1ns / 1ps

package dgtsb_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int COORD_W    = $clog2(MAX_DIM);
    localparam int DIM_W      = COORD_W + 1;
    localparam int QUAD_W     = 7;
    localparam int HALF_W     = 13;
    localparam int DEPTH_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_QUAD_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam logic [QUAD_W-1:0] QUAD_SIZE_RESET    = 7'd5;
    localparam logic [DIM_W-1:0]  IMAGE_WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0]  IMAGE_HEIGHT_RESET = 13'd480;

    localparam logic [DEPTH_W-1:0] EMPTY_DEPTH = 8'hFF;

    localparam int CQ_DEPTH = 2;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    typedef struct packed {
        logic [DEPTH_W-1:0] depth_here;
        logic [DEPTH_W-1:0] depth_above;
    } in_t;

    typedef struct packed {
        logic [HALF_W-1:0]  vertex_x_half;
        logic [HALF_W-1:0]  vertex_y_half;
        logic [DEPTH_W-1:0] vertex_depth;
        logic               last_of_run;
    } out_t;

    typedef struct packed {
        logic [HALF_W-1:0]  x_half;
        logic [HALF_W-1:0]  y_half;
        logic [DEPTH_W-1:0] depth;
    } vtx_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth_here;
        logic [DEPTH_W-1:0] depth_above;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] up;
        logic [COORD_W-1:0] left;
        logic               row_end;
        logic               frame_end;
    } cmd_t;

    function automatic logic [HALF_W-1:0] half_unit(input logic [COORD_W-1:0] v);
        return HALF_W'({v, 1'b1});
    endfunction

endpackage

// File: hdl/depth_grid_triangle_strip_builder.sv
// Builds triangle-strip vertices from a depth grid sampled every quad_size pixels.
// Each request carries the depth at the current grid point and at the point one quad
// row above; the block tracks column and row itself, walking each row left to right
// and wrapping to the first row after the last. Results come out one vertex at a
// time, and last_of_run marks the final vertex caused by a request (a request may
// cause none). The front end takes one request per cycle, unless full, into a
// two-entry command queue; the back end sequencer steps through the vertices of
// each request, also taking a step for each grid point that yields no vertex. A
// four-entry result queue sits between the sequencer and the output. Configuration
// registers (0: quad_size, 1: image_width, 2: image_height) are written by the user
// via cfg_write, cfg_index and cfg_data only while the block is idle (not enforced).
`timescale 1ns / 1ps

module depth_grid_triangle_strip_builder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  dgtsb_pkg::in_t                      item,
    output logic                                empty,
    input  logic                                pop,
    output dgtsb_pkg::out_t                     vertex,
    input  logic                                cfg_write,
    input  logic [dgtsb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dgtsb_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import dgtsb_pkg::*;

    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    dgtsb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    dgtsb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .vertex    (vertex)
    );

endmodule

// File: hdl/dgtsb_front.sv
`timescale 1ns / 1ps

module dgtsb_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  dgtsb_pkg::in_t                      item,
    input  logic                                cfg_write,
    input  logic [dgtsb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dgtsb_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                                cmd_valid,
    output dgtsb_pkg::cmd_t                     cmd,
    input  logic                                cmd_pop
);
    import dgtsb_pkg::*;

    logic [QUAD_W-1:0]   quad_reg;
    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;
    logic [COORD_W-1:0]  col_reg;
    logic [COORD_W-1:0]  col_next;
    logic [COORD_W-1:0]  row_reg;
    logic [COORD_W-1:0]  row_next;
    cmd_t                cq_mem [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] cq_wr_reg;
    logic [CQ_PTR_W-1:0] cq_rd_reg;
    logic [CQ_CNT_W-1:0] cq_count_reg;
    logic [CQ_CNT_W-1:0] cq_count_next;

    logic [QUAD_W-1:0]   q_eff;
    logic [DIM_W-1:0]    w_eff;
    logic [DIM_W-1:0]    h_eff;
    logic [DIM_W-1:0]    col_sum;
    logic [DIM_W-1:0]    row_sum;
    logic                accept;
    cmd_t                new_cmd;

    always_comb
    begin
        q_eff = (quad_reg == '0) ? QUAD_W'(1) : quad_reg;

        if (width_reg == '0)
            w_eff = DIM_W'(1);
        else if (width_reg > DIM_W'(MAX_DIM))
            w_eff = DIM_W'(MAX_DIM);
        else
            w_eff = width_reg;

        if (height_reg == '0)
            h_eff = DIM_W'(1);
        else if (height_reg > DIM_W'(MAX_DIM))
            h_eff = DIM_W'(MAX_DIM);
        else
            h_eff = height_reg;

        col_sum = {1'b0, col_reg} + DIM_W'(q_eff);
        row_sum = {1'b0, row_reg} + DIM_W'(q_eff);

        new_cmd.depth_here  = item.depth_here;
        new_cmd.depth_above = item.depth_above;
        new_cmd.col         = col_reg;
        new_cmd.row         = row_reg;
        new_cmd.up          = row_reg - COORD_W'(q_eff);
        new_cmd.left        = col_reg - COORD_W'(q_eff);
        new_cmd.row_end     = (col_sum >= w_eff);
        new_cmd.frame_end   = (row_sum >= h_eff);

        if (new_cmd.row_end)
        begin
            col_next = '0;
            row_next = new_cmd.frame_end ? COORD_W'(q_eff) : row_sum[COORD_W-1:0];
        end
        else
        begin
            col_next = col_sum[COORD_W-1:0];
            row_next = row_reg;
        end
    end

    assign full      = (cq_count_reg == CQ_CNT_W'(CQ_DEPTH));
    assign accept    = push && !full;
    assign cmd_valid = (cq_count_reg != '0);
    assign cmd       = cq_mem[cq_rd_reg];

    always_comb
    begin
        cq_count_next = cq_count_reg;
        if (accept && !cmd_pop)
            cq_count_next = cq_count_reg + CQ_CNT_W'(1);
        else if (!accept && cmd_pop)
            cq_count_next = cq_count_reg - CQ_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quad_reg     <= QUAD_SIZE_RESET;
            width_reg    <= IMAGE_WIDTH_RESET;
            height_reg   <= IMAGE_HEIGHT_RESET;
            col_reg      <= '0;
            row_reg      <= COORD_W'(QUAD_SIZE_RESET);
            cq_wr_reg    <= '0;
            cq_rd_reg    <= '0;
            cq_count_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_QUAD_SIZE:    quad_reg   <= cfg_data[QUAD_W-1:0];
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                    REG_IMAGE_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                    default:          ;
                endcase
            end
            if (accept)
            begin
                col_reg   <= col_next;
                row_reg   <= row_next;
                cq_wr_reg <= cq_wr_reg + CQ_PTR_W'(1);
            end
            if (cmd_pop)
                cq_rd_reg <= cq_rd_reg + CQ_PTR_W'(1);
            cq_count_reg <= cq_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            cq_mem[cq_wr_reg] <= new_cmd;
    end

endmodule

// File: hdl/dgtsb_back.sv
`timescale 1ns / 1ps

module dgtsb_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  dgtsb_pkg::cmd_t  cmd,
    output logic             cmd_pop,
    output logic             empty,
    input  logic             pop,
    output dgtsb_pkg::out_t  vertex
);
    import dgtsb_pkg::*;

    typedef enum logic [1:0] {
        PH_START,
        PH_PT0,
        PH_PT1,
        PH_END
    } phase_t;

    localparam logic [2:0] SLOT_PREV  = 3'd0;
    localparam logic [2:0] SLOT_FAR_A = 3'd1;
    localparam logic [2:0] SLOT_FAR_B = 3'd2;
    localparam logic [2:0] SLOT_NEAR  = 3'd3;
    localparam logic [2:0] SLOT_POINT = 3'd4;

    phase_t              phase_reg;
    phase_t              phase_next;
    logic                fresh_reg;
    logic                fresh_next;
    logic [2:0]          slot_reg;
    logic [2:0]          slot_next;
    logic [1:0]          full_reg;
    logic [1:0]          full_next;
    logic [1:0]          used_reg;
    logic [1:0]          used_next;
    logic                strip_reg;
    logic                strip_next;
    logic                any_reg;
    logic                any_next;
    vtx_t                prev_reg;
    vtx_t                prev_next;
    logic [DEPTH_W-1:0]  dep_reg [2];
    logic [DEPTH_W-1:0]  dep_next [2];
    out_t                pend_reg;
    logic                pend_valid_reg;
    out_t                oq_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] oq_wr_reg;
    logic [OQ_PTR_W-1:0] oq_rd_reg;
    logic [OQ_CNT_W-1:0] oq_count_reg;
    logic [OQ_CNT_W-1:0] oq_count_next;

    phase_t              eff_phase;
    logic                rs_needed;
    logic                is_pt1;
    logic [COORD_W-1:0]  px;
    logic [COORD_W-1:0]  py;
    logic [COORD_W-1:0]  nx;
    logic [COORD_W-1:0]  ny;
    logic [COORD_W-1:0]  fx;
    logic [COORD_W-1:0]  fy;
    logic [DEPTH_W-1:0]  pd;
    logic [DEPTH_W-1:0]  fd;
    logic                pd_full;
    logic                pt_has;
    logic                pt_skip;
    logic [2:0]          start_slot;
    logic [2:0]          cur_slot;
    vtx_t                slot_v;
    vtx_t                new_v;
    logic                emit;
    logic                step_end;
    logic                oq_full;
    logic                back_go;
    logic                oq_push;
    logic                oq_pop;

    assign rs_needed = (cmd.col == '0) &&
                       ((cmd.depth_here != EMPTY_DEPTH) || (cmd.depth_above != EMPTY_DEPTH));
    assign eff_phase = ((phase_reg == PH_START) && !rs_needed) ? PH_PT0 : phase_reg;
    assign is_pt1    = (eff_phase == PH_PT1);

    // The second point of a pair lies one quad row up; its neighbors shift accordingly.
    always_comb
    begin
        px      = cmd.col;
        py      = is_pt1 ? cmd.up : cmd.row;
        pd      = is_pt1 ? cmd.depth_above : cmd.depth_here;
        nx      = is_pt1 ? cmd.col : cmd.left;
        ny      = is_pt1 ? cmd.row : cmd.up;
        fx      = cmd.left;
        fy      = is_pt1 ? cmd.up : cmd.row;
        fd      = full_reg[1] ? dep_reg[1] : dep_reg[0];
        pd_full = (pd != EMPTY_DEPTH);

        pt_has     = 1'b0;
        pt_skip    = 1'b0;
        start_slot = SLOT_POINT;
        if (pd_full)
        begin
            if (full_reg[0] || full_reg[1] || (used_reg[0] && used_reg[1]))
            begin
                pt_has = 1'b1;
            end
            else if (used_reg[0] && !used_reg[1])
            begin
                pt_has     = 1'b1;
                start_slot = SLOT_NEAR;
            end
            else if (!used_reg[0] && !used_reg[1])
            begin
                pt_has     = 1'b1;
                start_slot = any_reg ? SLOT_PREV : SLOT_FAR_A;
            end
            else
            begin
                pt_skip = 1'b1;
            end
        end
        else if (full_reg[0] || full_reg[1])
        begin
            pt_has = 1'b1;
        end

        cur_slot = fresh_reg ? start_slot : slot_reg;

        case (cur_slot)
            SLOT_PREV:  slot_v = prev_reg;
            SLOT_FAR_A,
            SLOT_FAR_B: slot_v = '{half_unit(fx), half_unit(fy), pd};
            SLOT_NEAR:  slot_v = '{half_unit(nx), half_unit(ny), pd};
            default:    slot_v = '{half_unit(px), half_unit(py), pd_full ? pd : fd};
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        fresh_next  = fresh_reg;
        slot_next   = slot_reg;
        full_next   = full_reg;
        used_next   = used_reg;
        strip_next  = strip_reg;
        any_next    = any_reg;
        prev_next   = prev_reg;
        dep_next[0] = dep_reg[0];
        dep_next[1] = dep_reg[1];
        emit        = 1'b0;
        step_end    = 1'b0;
        new_v       = slot_v;

        case (eff_phase)
            PH_START:
            begin
                emit       = 1'b1;
                new_v      = '{half_unit(COORD_W'(0)), half_unit(cmd.row),
                               (cmd.depth_here != EMPTY_DEPTH) ? cmd.depth_here
                                                               : cmd.depth_above};
                phase_next = PH_PT0;
                fresh_next = 1'b1;
            end
            PH_PT0,
            PH_PT1:
            begin
                emit = pt_has;
                if (pt_has && (cur_slot != SLOT_POINT))
                begin
                    slot_next  = cur_slot + 3'd1;
                    fresh_next = 1'b0;
                end
                else
                begin
                    fresh_next = 1'b1;
                    if (!pt_skip)
                    begin
                        if (pd_full)
                        begin
                            full_next  = {1'b1, full_reg[1]};
                            used_next  = (start_slot == SLOT_POINT) ? {1'b1, used_reg[1]}
                                                                    : 2'b11;
                            strip_next = 1'b1;
                        end
                        else
                        begin
                            full_next = {1'b0, full_reg[1]};
                            used_next = {pt_has, used_reg[1]};
                            if (pt_has)
                                strip_next = 1'b1;
                        end
                        dep_next[0] = dep_reg[1];
                        dep_next[1] = pd;
                    end
                    if (!is_pt1)
                        phase_next = PH_PT1;
                    else if (cmd.row_end && strip_next)
                        phase_next = PH_END;
                    else
                        step_end = 1'b1;
                end
            end
            PH_END:
            begin
                emit     = 1'b1;
                new_v    = prev_reg;
                step_end = 1'b1;
            end
            default:
            begin
                step_end = 1'b1;
            end
        endcase

        if (emit)
        begin
            prev_next = new_v;
            any_next  = 1'b1;
        end

        if (step_end)
        begin
            phase_next = PH_START;
            fresh_next = 1'b1;
            if (cmd.row_end)
            begin
                full_next  = 2'b00;
                used_next  = 2'b11;
                strip_next = 1'b0;
            end
            if (cmd.row_end && cmd.frame_end)
                any_next = 1'b0;
        end
    end

    // The newest vertex waits in a holding register until it is known whether it
    // closes its request; it then moves into the output queue.
    assign oq_full = (oq_count_reg == OQ_CNT_W'(OQ_DEPTH));
    assign back_go = cmd_valid && !(pend_valid_reg && (pend_reg.last_of_run || emit) && oq_full);
    assign oq_push = pend_valid_reg && !oq_full && (pend_reg.last_of_run || (cmd_valid && emit));
    assign oq_pop  = pop && !empty;
    assign cmd_pop = back_go && step_end;
    assign empty   = (oq_count_reg == '0);
    assign vertex  = oq_mem[oq_rd_reg];

    always_comb
    begin
        oq_count_next = oq_count_reg;
        if (oq_push && !oq_pop)
            oq_count_next = oq_count_reg + OQ_CNT_W'(1);
        else if (!oq_push && oq_pop)
            oq_count_next = oq_count_reg - OQ_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_START;
            fresh_reg      <= 1'b1;
            slot_reg       <= SLOT_PREV;
            full_reg       <= 2'b00;
            used_reg       <= 2'b11;
            strip_reg      <= 1'b0;
            any_reg        <= 1'b0;
            prev_reg       <= '0;
            pend_valid_reg <= 1'b0;
            oq_wr_reg      <= '0;
            oq_rd_reg      <= '0;
            oq_count_reg   <= '0;
        end
        else
        begin
            if (back_go)
            begin
                phase_reg <= phase_next;
                fresh_reg <= fresh_next;
                slot_reg  <= slot_next;
                full_reg  <= full_next;
                used_reg  <= used_next;
                strip_reg <= strip_next;
                any_reg   <= any_next;
                prev_reg  <= prev_next;
            end

            if (back_go && emit)
                pend_valid_reg <= 1'b1;
            else if (oq_push)
                pend_valid_reg <= 1'b0;

            if (oq_push)
                oq_wr_reg <= oq_wr_reg + OQ_PTR_W'(1);
            if (oq_pop)
                oq_rd_reg <= oq_rd_reg + OQ_PTR_W'(1);
            oq_count_reg <= oq_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (back_go)
        begin
            dep_reg[0] <= dep_next[0];
            dep_reg[1] <= dep_next[1];
        end
        if (back_go && emit)
            pend_reg <= '{new_v.x_half, new_v.y_half, new_v.depth, step_end};
        else if (back_go && step_end)
            pend_reg.last_of_run <= 1'b1;
        if (oq_push)
            oq_mem[oq_wr_reg] <= pend_reg;
    end

endmodule

// File: hdl/dgtsb_checker.sv
`timescale 1ns / 1ps

`include "depth_grid_triangle_strip_builder_assert.svh"

module dgtsb_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             empty,
    input  logic             pop,
    input  dgtsb_pkg::out_t  vertex
);
    import dgtsb_pkg::*;

    // Every vertex lies at a pixel center, so both half-pixel coordinates are odd.
    `DGTSB_ASSERT_ALWAYS(a_half_odd, empty || (vertex.vertex_x_half[0] && vertex.vertex_y_half[0]))

    // A vertex never carries the empty marker as its depth.
    `DGTSB_ASSERT_ALWAYS(a_depth_real, empty || (vertex.vertex_depth != EMPTY_DEPTH))

    // A waiting result stays in place until it is taken.
    `DGTSB_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(vertex))

endmodule

bind depth_grid_triangle_strip_builder dgtsb_checker u_checker (.*);
